FILE: hw/rtl/cdr_pkg.sv
// Shared types and constants for the circular deque with rotate unit.
// Holds the request and response payload structs, operation codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
package cdr_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_ADD_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ROTATE    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  removed_value;
      logic                found;
      logic [VALUE_W-1:0]  first_value;
      logic [VALUE_W-1:0]  last_value;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ADD_FRONT,
      OP_ADD_BACK,
      OP_REMOVE,
      OP_ROTATE,
      OP_SEARCH,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

FILE: hw/rtl/cdr_fifo.sv
// Two-entry register queue used between the front, the back and the response port.
// Carries an opaque bit vector of DATA_W bits. No package dependencies.
`timescale 1ns / 1ps
module cdr_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/cdr_front.sv
// Front end: accepts requests, decodes the function code and queues commands.
// Depends on cdr_pkg and cdr_fifo.
`timescale 1ns / 1ps
module cdr_front
   import cdr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    cmd_pop,
   output logic    cmd_valid,
   output cmd_type cmd_data
);

   cmd_type                 cmd_dec;
   logic                    cmd_empty;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   // Map the raw code to an operation; unused codes do nothing.
   always_comb begin
      cmd_dec.value = req_data.value;
      case (req_data.func)
         FUNC_ADD_FRONT: cmd_dec.op = OP_ADD_FRONT;
         FUNC_ADD_BACK:  cmd_dec.op = OP_ADD_BACK;
         FUNC_REMOVE:    cmd_dec.op = OP_REMOVE;
         FUNC_ROTATE:    cmd_dec.op = OP_ROTATE;
         FUNC_SEARCH:    cmd_dec.op = OP_SEARCH;
         default:        cmd_dec.op = OP_NOP;
      endcase
   end

   cdr_fifo #(
      .DATA_W ($bits(cmd_type))
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_dec),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_bits)
   );

   assign cmd_valid = ~cmd_empty;
   assign cmd_data  = cmd_type'(cmd_bits);

endmodule

FILE: hw/rtl/cdr_back.sv
// Back end: shifting register store of the deque, executes one command at a time.
// Depends on cdr_pkg.
`timescale 1ns / 1ps
module cdr_back
   import cdr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int WIDTH = WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   localparam int ELEM_W = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
   localparam int OCC_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_EXEC   = 2'b01,
      ST_REDUCE = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [ELEM_W-1:0] cells_ff [DEPTH];
   logic [ELEM_W-1:0] cells_in [DEPTH];
   logic [ELEM_W-1:0] last_ff, last_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [DEPTH-1:0]  match_ff, match_in;
   logic [ELEM_W-1:0] v;
   logic              go, is_full, is_empty;
   logic              do_add_front, do_add_back, do_remove, do_rotate, do_search;

   assign v        = cmd_data.value[ELEM_W-1:0];
   assign is_full  = (occ_ff == OCC_W'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign go       = (state_ff == ST_EXEC) && cmd_valid && !rsp_full;
   assign cmd_pop  = go;

   assign do_add_front = go && (cmd_data.op == OP_ADD_FRONT) && !is_full;
   assign do_add_back  = go && (cmd_data.op == OP_ADD_BACK) && !is_full;
   assign do_remove    = go && (cmd_data.op == OP_REMOVE) && !is_empty;
   assign do_rotate    = go && (cmd_data.op == OP_ROTATE) && !is_empty;
   assign do_search    = go && (cmd_data.op == OP_SEARCH);

   // Each cell picks from its fixed neighbors, the new value or, on rotate, cell 0.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_W-1:0] prev_val;
      logic [ELEM_W-1:0] next_val;
      if (g == 0) begin : g_first
         assign prev_val = v;
      end else begin : g_mid
         assign prev_val = cells_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_val = cells_ff[g];
      end else begin : g_inner
         assign next_val = cells_ff[g+1];
      end

      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_add_front) begin
            cells_in[g] = prev_val;
         end else if (do_add_back && (occ_ff == OCC_W'(g))) begin
            cells_in[g] = v;
         end else if (do_remove) begin
            cells_in[g] = next_val;
         end else if (do_rotate) begin
            cells_in[g] = (occ_ff == OCC_W'(g + 1)) ? cells_ff[0] : next_val;
         end
      end

      assign match_in[g] = (cells_ff[g] == v) && (OCC_W'(g) < occ_ff);
   end

   always_comb begin
      occ_in  = occ_ff;
      last_in = last_ff;
      if (do_add_front) begin
         occ_in  = occ_ff + 1'b1;
         last_in = is_empty ? v : last_ff;
      end else if (do_add_back) begin
         occ_in  = occ_ff + 1'b1;
         last_in = v;
      end else if (do_remove) begin
         occ_in  = occ_ff - 1'b1;
      end else if (do_rotate) begin
         last_in = cells_ff[0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EXEC:   state_in = do_search ? ST_REDUCE : ST_EXEC;
         ST_REDUCE: state_in = ST_EXEC;
         default:   state_in = ST_EXEC;
      endcase
   end

   // Build the response from the post-operation view of the store.
   always_comb begin
      rsp_data.removed_value = do_remove ? VALUE_W'(cells_ff[0]) : '0;
      rsp_data.found         = 1'b0;
      rsp_data.first_value   = (occ_in != '0) ? VALUE_W'(cells_in[0]) : '0;
      rsp_data.last_value    = (occ_in != '0) ? VALUE_W'(last_in) : '0;
      rsp_data.count         = COUNT_W'(occ_in);
      rsp_data.status        = STATUS_OK;
      rsp_push               = 1'b0;
      if (state_ff == ST_REDUCE) begin
         rsp_push        = 1'b1;
         rsp_data.found  = |match_ff;
         rsp_data.status = is_empty ? STATUS_EMPTY : STATUS_OK;
      end else if (go && !do_search) begin
         rsp_push = 1'b1;
         case (cmd_data.op)
            OP_ADD_FRONT, OP_ADD_BACK: rsp_data.status = is_full ? STATUS_FULL : STATUS_OK;
            OP_REMOVE, OP_ROTATE:      rsp_data.status = is_empty ? STATUS_EMPTY : STATUS_OK;
            default:                   rsp_data.status = STATUS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXEC;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (do_search) begin
         match_ff <= match_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

endmodule

FILE: hw/rtl/circular_deque_with_rotate_unit.sv
// Top level of the circular deque with rotate unit.
// Depends on cdr_pkg, cdr_fifo, cdr_front and cdr_back.
//
//   channel   ports                          role
//   request   req_push  req_full  req_data   func and value of one operation
//   response  rsp_pop   rsp_empty rsp_data   state of the deque after the operation
//
// A transaction is registered in a two-entry command queue, executed by the
// engine and its response registered in a two-entry response queue; a search
// also passes through the engine's match register and reduce state. The engine
// retires add, remove, rotate and unused codes at one per cycle while the
// response queue is not full; a search runs as a per-cell compare, then an OR
// reduction. Reset is synchronous, active high, and empties the deque and both
// queues. A full response queue stalls the engine, which in turn fills the
// command queue and raises req_full.
`timescale 1ns / 1ps
module circular_deque_with_rotate_unit
   import cdr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int WIDTH = WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;
   logic    eng_push;
   logic    eng_full;
   rsp_type eng_data;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // Decode and queue incoming transactions.
   cdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data)
   );

   // Execute against the register store; hold while the response queue is full.
   cdr_back #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (eng_full),
      .rsp_push  (eng_push),
      .rsp_data  (eng_data)
   );

   // Buffer responses so the engine advances while the consumer stalls.
   cdr_fifo #(
      .DATA_W ($bits(rsp_type))
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_data),
      .full      (eng_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for circular_deque_with_rotate_unit: directed table, then random traffic.
// Depends on cdr_pkg and the RTL of the unit; responses are checked against an in-bench predictor.
`timescale 1ns / 1ps
module testbench
   import cdr_pkg::*;
();

   localparam int DEQUE_DEPTH   = DEPTH_DEF;
   localparam int ITEM_TARGET   = 1350;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RECENT_KEEP   = 24;

   // Function codes the unit treats as no-ops.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] TOP_BIT  = 32'h8000_0000;

   typedef enum int {
      SEQ_FILL,
      SEQ_DRAIN,
      SEQ_MIXED
   } seq_kind_type;

   // One row of the directed table; answer is used only where typed is set.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   // Travels alongside each offered transaction until it is accepted.
   typedef struct {
      bit      typed;
      rsp_type answer;
   } offer_note_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    req_full;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;
   logic    rsp_empty;

   circular_deque_with_rotate_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   always #5 clock = ~clock;

   // Predictor state: the deque contents, front at index 0.
   logic [VALUE_W-1:0] deque_cells[$];
   // Deque states the unit still owes us, oldest first.
   rsp_type            awaited_states[$];
   offer_note_type     offered_notes[$];

   // Stimulus-side shadow of the occupancy and of values recently added,
   // kept apart from the predictor so generation never races the monitor.
   int                 planned_count = 0;
   logic [VALUE_W-1:0] recent_values[$];

   int errors        = 0;
   int accepted_reqs = 0;
   int retired_rsps  = 0;
   int full_seen     = 0;
   int empty_seen    = 0;
   int found_seen    = 0;
   int peak_count    = 0;
   int cycle_count   = 0;
   bit hold_requested = 1'b0;

   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("mismatch @%0d after %0d responses: %s got %h want %h",
               cycle_count, retired_rsps, what, got, want);
      errors++;
   endtask

   // Apply one operation to the predicted deque and return the state it
   // leaves behind, the way the unit reports it.
   function automatic rsp_type apply_deque_op(req_type r);
      rsp_type s;
      s = '0;
      case (r.func)
         FUNC_ADD_FRONT, FUNC_ADD_BACK: begin
            if (deque_cells.size() >= DEQUE_DEPTH) begin
               s.status = STATUS_FULL;
            end else if (r.func == FUNC_ADD_FRONT) begin
               deque_cells.push_front(r.value);
            end else begin
               deque_cells.push_back(r.value);
            end
         end
         FUNC_REMOVE: begin
            if (deque_cells.size() == 0) begin
               s.status = STATUS_EMPTY;
            end else begin
               s.removed_value = deque_cells.pop_front();
            end
         end
         FUNC_ROTATE: begin
            if (deque_cells.size() == 0) begin
               s.status = STATUS_EMPTY;
            end else begin
               deque_cells.push_back(deque_cells.pop_front());
            end
         end
         FUNC_SEARCH: begin
            if (deque_cells.size() == 0) begin
               s.status = STATUS_EMPTY;
            end else begin
               foreach (deque_cells[i])
                  if (deque_cells[i] == r.value)
                     s.found = 1'b1;
            end
         end
         default: begin
            // spare codes leave everything as it is
         end
      endcase
      if (deque_cells.size() != 0) begin
         s.first_value = deque_cells[0];
         s.last_value  = deque_cells[$];
      end
      s.count = COUNT_W'(deque_cells.size());
      return s;
   endfunction

   function automatic rsp_type deque_view(logic [VALUE_W-1:0] removed, logic found,
                                          logic [VALUE_W-1:0] first, logic [VALUE_W-1:0] last,
                                          int count, logic [STATUS_W-1:0] status);
      rsp_type s;
      s.removed_value = removed;
      s.found         = found;
      s.first_value   = first;
      s.last_value    = last;
      s.count         = COUNT_W'(count);
      s.status        = status;
      return s;
   endfunction

   function automatic stim_row_type row(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                        bit typed, rsp_type answer);
      stim_row_type t;
      t.req.func  = f;
      t.req.value = v;
      t.typed     = typed;
      t.answer    = answer;
      return t;
   endfunction

   task automatic check_response(rsp_type want, rsp_type got);
      if (got.removed_value !== want.removed_value)
         report_mismatch("removed_value", got.removed_value, want.removed_value);
      if (got.found !== want.found)
         report_mismatch("found", VALUE_W'(got.found), VALUE_W'(want.found));
      if (got.first_value !== want.first_value)
         report_mismatch("first_value", got.first_value, want.first_value);
      if (got.last_value !== want.last_value)
         report_mismatch("last_value", got.last_value, want.last_value);
      if (got.count !== want.count)
         report_mismatch("count", VALUE_W'(got.count), VALUE_W'(want.count));
      if (got.status !== want.status)
         report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
   endtask

   // Mostly random words, with the corner patterns mixed in now and then.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return TOP_BIT;
         3:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // Searches aim at something added recently more often than not, so
   // both hits and misses come up.
   function automatic req_type plan_op(logic [FUNC_W-1:0] f);
      req_type r;
      r.func = f;
      if (f == FUNC_SEARCH && recent_values.size() != 0 && $urandom_range(0, 9) < 6)
         r.value = recent_values[$urandom_range(0, recent_values.size() - 1)];
      else
         r.value = pick_value();
      return r;
   endfunction

   function automatic void track_plan(req_type r);
      if (r.func == FUNC_ADD_FRONT || r.func == FUNC_ADD_BACK) begin
         if (planned_count < DEQUE_DEPTH)
            planned_count++;
         recent_values.push_back(r.value);
         if (recent_values.size() > RECENT_KEEP)
            void'(recent_values.pop_front());
      end else if (r.func == FUNC_REMOVE && planned_count > 0) begin
         planned_count--;
      end
   endfunction

   // Offer one transaction and hold it until the unit takes it. The gap
   // before it is drawn here; eager mode skips the gap entirely. When the
   // gap is zero, push stays high straight into the next transaction.
   task automatic send_item(req_type r, bit typed, rsp_type answer, bit eager);
      int             gap;
      offer_note_type note;
      gap = eager ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.typed  = typed;
      note.answer = answer;
      offered_notes.push_back(note);
      track_plan(r);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
   endtask

   // Fill runs on until a few adds have bounced off a full deque, drain
   // until a few operations have hit an empty one; mixed is a short burst
   // of everything, spare codes included.
   task automatic run_sequence(seq_kind_type kind, bit eager);
      int                budget;
      int                roll;
      logic [FUNC_W-1:0] f;
      budget = (kind == SEQ_MIXED) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      while (budget > 0) begin
         roll = $urandom_range(0, 99);
         case (kind)
            SEQ_FILL: begin
               f = (roll < 45) ? FUNC_ADD_FRONT :
                   (roll < 90) ? FUNC_ADD_BACK  :
                   (roll < 95) ? FUNC_ROTATE    : FUNC_SEARCH;
            end
            SEQ_DRAIN: begin
               f = (roll < 70) ? FUNC_REMOVE :
                   (roll < 85) ? FUNC_ROTATE : FUNC_SEARCH;
            end
            default: begin
               f = (roll < 20) ? FUNC_ADD_FRONT :
                   (roll < 40) ? FUNC_ADD_BACK  :
                   (roll < 65) ? FUNC_REMOVE    :
                   (roll < 80) ? FUNC_ROTATE    :
                   (roll < 97) ? FUNC_SEARCH    :
                   (roll == 97) ? FUNC_SPARE_5  :
                   (roll == 98) ? FUNC_SPARE_6  : FUNC_SPARE_7;
            end
         endcase
         if (kind == SEQ_FILL) begin
            if (planned_count == DEQUE_DEPTH && (f == FUNC_ADD_FRONT || f == FUNC_ADD_BACK))
               budget--;
         end else if (kind == SEQ_DRAIN) begin
            if (planned_count == 0)
               budget--;
         end else begin
            budget--;
         end
         send_item(plan_op(f), 1'b0, '0, eager);
      end
   endtask

   // Monitor both channels at the rising edge. Acceptance is handled first
   // so an expectation is always queued before its response can be popped.
   always @(posedge clock) begin : channel_monitor
      offer_note_type note;
      rsp_type        predicted;
      cycle_count++;
      if (!reset && req_push && !req_full) begin
         accepted_reqs++;
         note      = offered_notes.pop_front();
         predicted = apply_deque_op(req_data);
         if (predicted.status == STATUS_FULL)
            full_seen++;
         if (predicted.status == STATUS_EMPTY)
            empty_seen++;
         if (predicted.found)
            found_seen++;
         if (deque_cells.size() > peak_count)
            peak_count = deque_cells.size();
         // typed rows carry their own answer; the predictor still advances
         awaited_states.push_back(note.typed ? note.answer : predicted);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         retired_rsps++;
         if (awaited_states.size() == 0)
            report_mismatch("response with nothing outstanding", rsp_data.first_value, '0);
         else
            check_response(awaited_states.pop_front(), rsp_data);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_states.size());
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stalls per transaction, occasional brisk stretches
   // with no stall at all, and one long hold-off when the sender asks for it.
   initial begin : response_drain
      int stall;
      int brisk_left;
      brisk_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (brisk_left > 0) begin
               brisk_left--;
               stall = 0;
            end else begin
               stall = $urandom_range(0, 9);
               if ($urandom_range(0, 15) == 0)
                  brisk_left = $urandom_range(10, 40);
            end
            if (stall > 0) begin
               rsp_pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows[$];
      int           drain_wait;
      int           roll;
      bit           held_once;
      bit           paused_once;
      held_once   = 1'b0;
      paused_once = 1'b0;

      // Empty deque: every operation reads as zero, removes, rotates and
      // searches report empty, spare codes are quiet no-ops.
      directed_rows.push_back(row(FUNC_REMOVE, '0, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_EMPTY)));
      directed_rows.push_back(row(FUNC_ROTATE, ALL_ONES, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_EMPTY)));
      directed_rows.push_back(row(FUNC_SEARCH, '0, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_EMPTY)));
      directed_rows.push_back(row(FUNC_SPARE_5, ALL_ONES, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(FUNC_SPARE_6, '0, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(FUNC_SPARE_7, TOP_BIT, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 0, STATUS_OK)));
      // Single element: rotate is a no-op, search hits, remove empties again.
      directed_rows.push_back(row(FUNC_ADD_FRONT, ALL_ONES, 1'b1,
                                  deque_view('0, 1'b0, ALL_ONES, ALL_ONES, 1, STATUS_OK)));
      directed_rows.push_back(row(FUNC_ROTATE, '0, 1'b1,
                                  deque_view('0, 1'b0, ALL_ONES, ALL_ONES, 1, STATUS_OK)));
      directed_rows.push_back(row(FUNC_SEARCH, ALL_ONES, 1'b1,
                                  deque_view('0, 1'b1, ALL_ONES, ALL_ONES, 1, STATUS_OK)));
      directed_rows.push_back(row(FUNC_REMOVE, '0, 1'b1,
                                  deque_view(ALL_ONES, 1'b0, '0, '0, 0, STATUS_OK)));
      directed_rows.push_back(row(FUNC_ADD_BACK, '0, 1'b1,
                                  deque_view('0, 1'b0, '0, '0, 1, STATUS_OK)));
      // A few elements at both ends, then searches, rotates and removes.
      directed_rows.push_back(row(FUNC_ADD_FRONT, TOP_BIT, 1'b0, '0));
      directed_rows.push_back(row(FUNC_ADD_BACK, 32'h0000_0001, 1'b0, '0));
      directed_rows.push_back(row(FUNC_ADD_FRONT, 32'h7FFF_FFFF, 1'b0, '0));
      directed_rows.push_back(row(FUNC_ADD_BACK, 32'hAAAA_5555, 1'b0, '0));
      directed_rows.push_back(row(FUNC_SEARCH, '0, 1'b0, '0));
      directed_rows.push_back(row(FUNC_SEARCH, 32'h1234_5678, 1'b0, '0));
      directed_rows.push_back(row(FUNC_ROTATE, '0, 1'b0, '0));
      directed_rows.push_back(row(FUNC_ROTATE, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(row(FUNC_SPARE_7, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(row(FUNC_REMOVE, '0, 1'b0, '0));
      directed_rows.push_back(row(FUNC_REMOVE, ALL_ONES, 1'b0, '0));
      directed_rows.push_back(row(FUNC_REMOVE, '0, 1'b0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].answer, 1'b0);

      // Open the random part by running straight into a full deque.
      run_sequence(SEQ_FILL, 1'b0);

      while (accepted_reqs < ITEM_TARGET) begin
         if (!held_once && accepted_reqs >= 400) begin
            // Hold the response side off and keep pushing back to back so
            // the internal queues back up and req_full has to assert.
            held_once      = 1'b1;
            hold_requested = 1'b1;
            run_sequence(SEQ_FILL, 1'b1);
            run_sequence(SEQ_MIXED, 1'b1);
         end else if (!paused_once && accepted_reqs >= 800) begin
            // Drop push and let every outstanding response come home.
            paused_once = 1'b1;
            req_push <= 1'b0;
            do @(posedge clock); while (awaited_states.size() != 0);
         end else begin
            roll = $urandom_range(0, 2);
            run_sequence(roll == 0 ? SEQ_FILL : roll == 1 ? SEQ_DRAIN : SEQ_MIXED,
                         $urandom_range(0, 3) == 0);
         end
      end

      // Wind down: stop pushing, wait for the last responses, then idle a
      // little longer so any stray response still shows up.
      req_push <= 1'b0;
      drain_wait = 0;
      do begin
         @(posedge clock);
         drain_wait++;
      end while (awaited_states.size() != 0 && drain_wait < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_states.size() != 0)
         report_mismatch("responses never returned", VALUE_W'(awaited_states.size()), '0);

      $display("ran %0d transactions in %0d cycles, %0d responses checked, %0d mismatches",
               accepted_reqs, cycle_count, retired_rsps, errors);
      $display("adds dropped on full: %0d, empty answers: %0d, search hits: %0d, peak count %0d",
               full_seen, empty_seen, found_seen, peak_count);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
